@@ rtl/core/dlrx_pkg.sv @@
// Shared types and constants for the display link receive deframer.
// Used by dlrx_parser and display_link_rx_deframer_core; no dependencies.

package dlrx_pkg;

  // Longest accepted frame length byte and the shortest one.
  localparam int MAX_FRAME_LEN = 64;
  localparam int MIN_FRAME_LEN = 3;

  // Payload position / remaining count: frame_length - 1 is the largest value.
  localparam int POS_W = $clog2(MAX_FRAME_LEN);

  typedef logic [POS_W-1:0] pos_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_HEADER_FIRST  = 2'd0;
  localparam cfg_idx_t CFG_HEADER_SECOND = 2'd1;
  localparam cfg_idx_t CFG_READ_COMMAND  = 2'd2;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'h5A;
  localparam logic [7:0] HEADER_SECOND_RST = 8'hA5;
  localparam logic [7:0] READ_COMMAND_RST  = 8'h83;

  // Request type codes.
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] read_command;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [15:0] vp_address;
    logic [7:0]  word_count;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic        has_data;
    logic        last;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_HDR1    = 5'b00010,
    ST_HDR2    = 5'b00100,
    ST_CMD     = 5'b01000,
    ST_PAYLOAD = 5'b10000
  } state_e;

endpackage

@@ rtl/core/dlrx_parser.sv @@
// Frame parser state and next-state logic: one item per step_i pulse.
// Depends on dlrx_pkg.

module dlrx_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  dlrx_pkg::req_t  req_i,
  input  dlrx_pkg::cfg_t  cfg_i,
  output logic            rsp_valid_o,
  output dlrx_pkg::rsp_t  rsp_o
);

  localparam logic [7:0] MaxLen = 8'(dlrx_pkg::MAX_FRAME_LEN);
  localparam logic [7:0] MinLen = 8'(dlrx_pkg::MIN_FRAME_LEN);

  dlrx_pkg::state_e state_q, state_d;
  dlrx_pkg::pos_t   remaining_q, remaining_d;
  dlrx_pkg::pos_t   pos_q, pos_d;
  logic             is_read_q, is_read_d;
  logic [15:0]      vp_q, vp_d;
  logic [7:0]       wc_q, wc_d;

  logic [7:0]       b;
  logic             fin;

  assign b   = req_i.rx_byte;
  assign fin = (remaining_q <= dlrx_pkg::pos_t'(1));

  always_comb begin
    state_d     = state_q;
    remaining_d = remaining_q;
    pos_d       = pos_q;
    is_read_d   = is_read_q;
    vp_d        = vp_q;
    wc_d        = wc_q;
    rsp_valid_o = 1'b0;
    rsp_o       = '0;

    if (req_i.req_type == dlrx_pkg::REQ_FLUSH) begin
      state_d = dlrx_pkg::ST_IDLE;
    end else begin
      case (state_q)
        dlrx_pkg::ST_HDR1: begin
          state_d = (b == cfg_i.header_second) ? dlrx_pkg::ST_HDR2 : dlrx_pkg::ST_IDLE;
        end
        dlrx_pkg::ST_HDR2: begin
          // Keep length - 1 directly as the payload count.
          if (b >= MinLen && b <= MaxLen) begin
            remaining_d = dlrx_pkg::pos_t'(b - 8'd1);
            state_d     = dlrx_pkg::ST_CMD;
          end else begin
            state_d = dlrx_pkg::ST_IDLE;
          end
        end
        dlrx_pkg::ST_CMD: begin
          is_read_d = (b == cfg_i.read_command);
          pos_d     = '0;
          vp_d      = '0;
          wc_d      = '0;
          state_d   = (remaining_q == '0) ? dlrx_pkg::ST_IDLE : dlrx_pkg::ST_PAYLOAD;
        end
        dlrx_pkg::ST_PAYLOAD: begin
          remaining_d = fin ? '0 : remaining_q - dlrx_pkg::pos_t'(1);
          pos_d       = pos_q + dlrx_pkg::pos_t'(1);
          if (fin) begin
            state_d = dlrx_pkg::ST_IDLE;
          end
          if (is_read_q) begin
            if (pos_q == dlrx_pkg::pos_t'(0)) begin
              vp_d = {b, 8'h00};
            end else if (pos_q == dlrx_pkg::pos_t'(1)) begin
              vp_d        = {vp_q[15:8], b};
              rsp_valid_o = fin;
            end else if (pos_q == dlrx_pkg::pos_t'(2)) begin
              wc_d        = b;
              rsp_valid_o = fin;
            end else begin
              rsp_valid_o      = 1'b1;
              rsp_o.data_byte  = b;
              rsp_o.data_index = 8'(pos_q) - 8'd3;
              rsp_o.has_data   = 1'b1;
            end
            rsp_o.vp_address = vp_d;
            rsp_o.word_count = wc_d;
            rsp_o.last       = fin;
          end
        end
        default: begin
          state_d = (b == cfg_i.header_first) ? dlrx_pkg::ST_HDR1 : dlrx_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlrx_pkg::ST_IDLE;
      remaining_q <= '0;
      pos_q       <= '0;
      is_read_q   <= 1'b0;
      vp_q        <= '0;
      wc_q        <= '0;
    end else if (step_i) begin
      state_q     <= state_d;
      remaining_q <= remaining_d;
      pos_q       <= pos_d;
      is_read_q   <= is_read_d;
      vp_q        <= vp_d;
      wc_q        <= wc_d;
    end
  end

endmodule

@@ rtl/core/display_link_rx_deframer_core.sv @@
// Display link receive deframer, top level: input register, parser, result register
// and configuration registers. Depends on dlrx_pkg and dlrx_parser.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i, in_stall_o, in_data_i    | receive
//  out     | out_valid_o, out_stall_i, out_data_o | send
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i     | receive
//
// One item per cycle sustained while out_stall_i does not hold a full result register; an
// accepted item waits in the input register, then the parser step loads the result register.
// rst_ni clears the parser to idle, empties both registers and loads the
// default header and command bytes.
// out_stall_i holding a full result register backs up into in_stall_o in the
// same cycle once the input register is also full.

module display_link_rx_deframer_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dlrx_pkg::req_t       in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dlrx_pkg::rsp_t       out_data_o,
  input  logic                 cfg_we_i,
  input  dlrx_pkg::cfg_idx_t   cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i
);

  logic            in_valid_q;
  dlrx_pkg::req_t  in_q;
  logic            out_valid_q;
  dlrx_pkg::rsp_t  out_q;
  dlrx_pkg::cfg_t  cfg_q;

  logic            advance;
  logic            rsp_valid;
  dlrx_pkg::rsp_t  rsp;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  dlrx_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .req_i       (in_q),
    .cfg_i       (cfg_q),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= rsp_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && rsp_valid) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= dlrx_pkg::HEADER_FIRST_RST;
      cfg_q.header_second <= dlrx_pkg::HEADER_SECOND_RST;
      cfg_q.read_command  <= dlrx_pkg::READ_COMMAND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dlrx_pkg::CFG_HEADER_FIRST:  cfg_q.header_first  <= cfg_wdata_i;
        dlrx_pkg::CFG_HEADER_SECOND: cfg_q.header_second <= cfg_wdata_i;
        dlrx_pkg::CFG_READ_COMMAND:  cfg_q.read_command  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A new result only appears after the parser took a step.
  a_rise_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("result appeared without a parser step");

  // An empty end marker is always the frame's last result.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.has_data || out_q.last))
    else $error("empty result not marked last");

  // A flush never yields a result.
  a_flush_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.req_type == dlrx_pkg::REQ_FLUSH) |=> !out_valid_q)
    else $error("flush produced a result");

  // Input backs up only when the result register is full and stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without downstream stall");

endmodule
